// File: sv/sdaf_pkg.sv
// Shared types, character codes and the power-of-ten multiple table of the decimal formatter.
`default_nettype none

package sdaf_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CHAR_W = 6;
	localparam int unsigned MAG_W = 34;
	localparam int unsigned NUM_POS = 10;
	localparam int unsigned NUM_MULT = 9;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned DIGIT_W = 4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POS - 1);
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

	typedef logic [NUM_MULT-1:0][MAG_W-1:0] mult_row_t;
	typedef mult_row_t [NUM_POS-1:0] mult_tab_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic emit_sign;
		logic step;
	} sdaf_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic neg;
		logic emit_digit;
		logic last_digit;
	} sdaf_sts_t;

	// Row i holds 1..9 times 10^(9-i); row 0 is the billions place.
	function automatic mult_tab_t build_mult_tab();
		mult_tab_t tab;
		logic [MAG_W-1:0] p;
		tab = '0;
		p = MAG_W'(1);
		for (int i = NUM_POS - 1; i >= 0; i--) begin
			for (int k = 0; k < NUM_MULT; k++) begin
				tab[i][k] = MAG_W'(p * MAG_W'(k + 1));
			end
			p = MAG_W'(p * MAG_W'(10));
		end
		return tab;
	endfunction

	localparam mult_tab_t MULT_TAB = build_mult_tab();

endpackage

`default_nettype wire

// File: sv/sdaf_datapath.sv
// Datapath of the decimal formatter: magnitude register, digit extraction and character register.
`default_nettype none

module sdaf_datapath
	import sdaf_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic signed [VALUE_W-1:0] value,
	input  wire sdaf_cmd_t                 cmd,
	output sdaf_sts_t                      sts,
	output logic        [CHAR_W-1:0]       char_code,
	output logic                           last
);

	logic [VALUE_W-1:0] mag_q;
	logic [IDX_W-1:0]   idx_q;
	logic               started_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic [VALUE_W-1:0] value_u;
	logic [VALUE_W-1:0] mag_in;
	mult_row_t          row;
	logic [MAG_W-1:0]   mag_ext;
	logic [MAG_W-1:0]   sub;
	logic [DIGIT_W-1:0] digit;

	assign value_u = unsigned'(value);
	assign mag_in  = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;

	// All nine multiples of the current place are compared at once; the
	// largest one not above the magnitude gives the digit.
	assign row     = MULT_TAB[idx_q];
	assign mag_ext = MAG_W'(mag_q);

	always_comb begin
		digit = '0;
		sub   = '0;
		for (int k = 0; k < NUM_MULT; k++) begin
			if (mag_ext >= row[k]) begin
				digit = DIGIT_W'(k + 1);
				sub   = row[k];
			end
		end
	end

	assign sts.neg        = value_u[VALUE_W-1];
	assign sts.last_digit = (idx_q == LAST_IDX);
	assign sts.emit_digit = (digit != '0) || started_q || (idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			started_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q     <= '0;
			started_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q     <= idx_q + IDX_W'(1);
			started_q <= sts.emit_digit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= mag_in;
		end else if (cmd.step) begin
			mag_q <= mag_q - sub[VALUE_W-1:0];
		end
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.step && sts.emit_digit) begin
			char_q <= CHAR_ZERO + CHAR_W'(digit);
			last_q <= sts.last_digit;
		end
	end

	assign char_code = char_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// File: sv/sdaf_ctrl.sv
// Controller of the decimal formatter: input handshake, sign and digit sequencing, output valid.
`default_nettype none

module sdaf_ctrl
	import sdaf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire sdaf_sts_t  sts,
	output sdaf_cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SIGN  = 2'd1;
	localparam logic [1:0] ST_DIGIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	// The character register can take a new beat when empty or being drained.
	assign slot_free = !out_valid_q || out_ready;

	assign in_ready      = (state_q == ST_IDLE);
	assign cmd.load      = (state_q == ST_IDLE) && in_valid;
	assign cmd.emit_sign = (state_q == ST_SIGN) && slot_free;
	assign cmd.step      = (state_q == ST_DIGIT) && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = sts.neg ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_SIGN: begin
				if (cmd.emit_sign) begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (cmd.step && sts.last_digit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_sign || (cmd.step && sts.emit_digit)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// A new number is taken only from idle, so ready drops right after a load.
	a_load_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("formatter stayed ready after taking a number");

	// The sign beat is always followed by the digit phase with a beat pending.
	a_sign_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) && slot_free |=> out_valid_q && (state_q == ST_DIGIT))
		else $error("sign beat not produced");

	// The units digit is always sent and ends the number.
	a_units_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && sts.last_digit |=> out_valid_q && (state_q == ST_IDLE))
		else $error("units digit missing or sequence not finished");

endmodule

`default_nettype wire

// File: sv/signed_decimal_ascii_formatter.sv
// Top level of the signed 32-bit integer to decimal ASCII formatter.
// Usage: a number enters as one beat on the input channel (in_valid, in_ready, value) and
// leaves as its decimal text, one ASCII character per beat on the output channel
// (out_valid, out_ready, char_code, last). A negative number first sends the minus sign
// and then the digits of its magnitude, so -2147483648 prints in full. Leading zeros are
// not sent, zero prints as a single '0', and last marks the final digit of each number.
// Sequence: in_ready is high only while the controller is idle. After a number is taken,
// the controller steps through the sign place (negative numbers only) and then each of
// the ten decimal places, billions down to units. Each place is resolved by comparing
// the magnitude against all nine multiples of its power of ten at once and subtracting
// the largest that fits. The minus sign is presented before the digits, and the units
// digit last. Suppressed leading zeros still take their place step, so the number of
// steps does not depend on the number of characters.
// Stalls: one output register holds the pending character; while it is full and
// out_ready is low, the place sequencer waits. A new number may be taken while the last
// character of the previous one still waits in that register.
// Reset: arst_n clears the controller to idle with no character pending.
`default_nettype none

module signed_decimal_ascii_formatter
	import sdaf_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [VALUE_W-1:0] value,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic        [CHAR_W-1:0]       char_code,
	output logic                           last
);

	sdaf_cmd_t cmd;
	sdaf_sts_t sts;

	// The controller sequences the sign and the ten places and owns both handshakes.
	sdaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the remaining magnitude and the outgoing character.
	sdaf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.char_code (char_code),
		.last      (last)
	);

endmodule

`default_nettype wire
